// ----- hw/rtl/bhs_pkg.sv -----
package bhs_pkg;

    // field widths
    localparam int KEY_W   = 31;
    localparam int COUNT_W = 13;

    // saturation value of the reported entry count
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_REPLACE = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    // request to the remainder unit
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] operand;
    } mod_req_t;

endpackage

// ----- hw/rtl/bucketed_hash_set.sv -----
// operation: the bucket index comes from a four-step reciprocal-multiply remainder unit that
//   runs once per key, followed by one row read and, when the row changes, one row write
// flow: one item at a time, next request accepted once the last result is registered
// reset: after rst_n releases, a clearing pass zeroes the valid bits, one bucket row a
//   cycle, over all BUCKETS rows, during which no beat is accepted
module bucketed_hash_set #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [1:0]                  operation,
    input  logic [bhs_pkg::KEY_W-1:0]   key,
    input  logic [bhs_pkg::KEY_W-1:0]   new_key,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic                        found,
    output logic [1:0]                  status,
    output logic [bhs_pkg::COUNT_W-1:0] entry_count
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int CNT_W = ($clog2(SLOTS + 1) > bhs_pkg::COUNT_W) ?
                           $clog2(SLOTS + 1) : bhs_pkg::COUNT_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MOD   = 6'b000100,
        S_READ  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef logic [WAYS-1:0][bhs_pkg::KEY_W-1:0] key_row_t;

    // bucket rows: valid bits and keys
    logic [WAYS-1:0] valid_mem [BUCKETS];
    key_row_t        key_mem   [BUCKETS];

    state_t                      state_reg;
    logic                        phase2_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [BKT_W-1:0]            clr_addr_reg;
    bhs_pkg::op_t                op_reg;
    logic [bhs_pkg::KEY_W-1:0]   key_reg;
    logic [bhs_pkg::KEY_W-1:0]   new_key_reg;
    logic                        found_reg;
    bhs_pkg::status_t            status_reg;
    logic [WAYS-1:0]             rd_valid_reg;
    key_row_t                    rd_key_reg;
    logic                        rsp_valid_reg;
    logic                        found_out_reg;
    bhs_pkg::status_t            status_out_reg;
    logic [bhs_pkg::COUNT_W-1:0] count_out_reg;

    bhs_pkg::mod_req_t           mod_req;
    logic                        mod_done;
    logic [BKT_W-1:0]            bucket;

    logic [bhs_pkg::KEY_W-1:0]   cur_key;
    logic [WAYS-1:0]             match;
    logic [WAYS-1:0]             free;
    logic [WAYS-1:0]             free_oh;
    logic                        hit;
    logic                        any_free;
    key_row_t                    ins_keys;
    logic                        do_insert;
    logic                        wr_en;
    logic [WAYS-1:0]             wr_valid;
    key_row_t                    wr_keys;
    logic                        cnt_inc;
    logic                        cnt_dec;
    bhs_pkg::status_t            chk_status;
    logic                        start_phase2;
    logic                        rsp_load;

    // shared remainder unit gives the bucket index
    bhs_mod_unit #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .done  (mod_done),
        .rem   (bucket)
    );

    always_comb
    begin
        mod_req.start   = ((state_reg == S_IDLE) && req_valid) || start_phase2;
        mod_req.operand = (state_reg == S_IDLE) ? key : new_key_reg;
    end

    // way compare and free-way pick over the row just read
    always_comb
    begin
        cur_key  = phase2_reg ? new_key_reg : key_reg;
        free     = ~rd_valid_reg;
        free_oh  = free & (~free + 1'b1);
        for (int w = 0; w < WAYS; w++)
        begin
            match[w]    = rd_valid_reg[w] && (rd_key_reg[w] == cur_key);
            ins_keys[w] = free_oh[w] ? cur_key : rd_key_reg[w];
        end
        hit      = |match;
        any_free = |free;
    end

    // row update decision
    always_comb
    begin
        do_insert    = phase2_reg || (op_reg == bhs_pkg::OP_INSERT);
        wr_en        = 1'b0;
        wr_valid     = rd_valid_reg;
        wr_keys      = rd_key_reg;
        cnt_inc      = 1'b0;
        cnt_dec      = 1'b0;
        chk_status   = bhs_pkg::ST_OK;
        start_phase2 = 1'b0;
        if (state_reg == S_CHECK)
        begin
            if (do_insert)
            begin
                if (!hit)
                begin
                    if (any_free)
                    begin
                        wr_en    = 1'b1;
                        wr_valid = rd_valid_reg | free_oh;
                        wr_keys  = ins_keys;
                        cnt_inc  = 1'b1;
                    end
                    else
                    begin
                        chk_status = bhs_pkg::ST_FULL;
                    end
                end
            end
            else
            begin
                case (op_reg) inside
                    bhs_pkg::OP_DELETE, bhs_pkg::OP_REPLACE:
                    begin
                        if (hit)
                        begin
                            wr_en    = 1'b1;
                            wr_valid = rd_valid_reg & ~match;
                            cnt_dec  = 1'b1;
                        end
                        if (op_reg == bhs_pkg::OP_REPLACE)
                        begin
                            if (hit)
                            begin
                                start_phase2 = 1'b1;
                            end
                            else
                            begin
                                chk_status = bhs_pkg::ST_ABSENT;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            phase2_reg    <= 1'b0;
            cnt_reg       <= '0;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cnt_dec && (cnt_reg != '0))
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == BKT_W'(BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        phase2_reg <= 1'b0;
                        state_reg  <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (start_phase2)
                    begin
                        phase2_reg <= 1'b1;
                        state_reg  <= S_MOD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (rsp_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

    // item payload and result registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req_valid)
        begin
            op_reg      <= bhs_pkg::op_t'(operation);
            key_reg     <= key;
            new_key_reg <= new_key;
        end
        if (state_reg == S_CHECK)
        begin
            status_reg <= chk_status;
            if (!phase2_reg)
            begin
                found_reg <= hit;
            end
        end
        if (rsp_load)
        begin
            found_out_reg  <= found_reg;
            status_out_reg <= status_reg;
            count_out_reg  <= (cnt_reg > CNT_W'(bhs_pkg::COUNT_MAX)) ?
                              bhs_pkg::COUNT_MAX : cnt_reg[bhs_pkg::COUNT_W-1:0];
        end
    end

    // bucket row memory: clearing pass, row write, registered row read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            valid_mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            valid_mem[bucket] <= wr_valid;
            key_mem[bucket]   <= wr_keys;
        end
        if (state_reg == S_READ)
        begin
            rd_valid_reg <= valid_mem[bucket];
            rd_key_reg   <= key_mem[bucket];
        end
    end

    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_out_reg;
    assign status      = status_out_reg;
    assign entry_count = count_out_reg;

    // stored count never exceeds the slot total
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("entry count above slot total");

    // remainder result only arrives while the sequencer waits for it
    a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_MOD))
        else $error("remainder done outside wait state");

    // a key is held in at most one way of its bucket
    a_unique_way: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> $onehot0(match))
        else $error("key matched in more than one way");

    // an absent replace never reports the key as found
    a_absent_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == bhs_pkg::ST_ABSENT)) |-> !found)
        else $error("replace absent with found set");

    // no result is pending while the clearing pass runs
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !rsp_valid_reg)
        else $error("result pending during clearing pass");

endmodule

// ----- hw/rtl/bhs_mod_unit.sv -----
module bhs_mod_unit #(
    parameter int BUCKETS = 1024,
    localparam int BKT_W  = $clog2(BUCKETS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bhs_pkg::mod_req_t  req,
    output logic               done,
    output logic [BKT_W-1:0]   rem
);

    // reciprocal multiply: floor(x / BUCKETS) = (x * RECIP) >> SHIFT for any 31-bit x
    localparam int MUL_LO_W = 17;
    localparam int MUL_HI_W = 16;
    localparam int PROD_W   = bhs_pkg::KEY_W + MUL_LO_W;
    localparam int SUM_W    = PROD_W + MUL_LO_W;
    localparam int SHIFT    = bhs_pkg::KEY_W + BKT_W;

    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [MUL_LO_W-1:0] RECIP_LO = RECIP[MUL_LO_W-1:0];
    localparam logic [MUL_HI_W-1:0] RECIP_HI = RECIP[MUL_LO_W+MUL_HI_W-1:MUL_LO_W];
    localparam logic [BKT_W-1:0]    D_LOW    = BKT_W'(BUCKETS);

    typedef enum logic [3:0] {
        STEP_LO  = 4'b0001,
        STEP_HI  = 4'b0010,
        STEP_SUM = 4'b0100,
        STEP_REM = 4'b1000
    } step_t;

    logic                      busy_reg;
    logic                      done_reg;
    step_t                     step_reg;
    logic [bhs_pkg::KEY_W-1:0] dividend_reg;
    logic [PROD_W-1:0]         lo_reg;
    logic [PROD_W-1:0]         hi_reg;
    logic [BKT_W-1:0]          quot_reg;
    logic [BKT_W-1:0]          rem_reg;

    logic [MUL_LO_W-1:0]       mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic [SUM_W-1:0]          prod_sum;
    logic [BKT_W-1:0]          quot_low;
    logic [BKT_W-1:0]          rem_low;

    // shared multiplier over the two halves of the reciprocal, then fold back
    always_comb
    begin
        mul_b    = (step_reg == STEP_LO) ? RECIP_LO : {1'b0, RECIP_HI};
        mul_p    = PROD_W'(dividend_reg) * PROD_W'(mul_b);
        prod_sum = {hi_reg, {MUL_LO_W{1'b0}}} + SUM_W'(lo_reg);
        quot_low = BKT_W'(prod_sum >> SHIFT);
        rem_low  = dividend_reg[BKT_W-1:0] - (quot_reg * D_LOW);
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LO;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_REM);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_LO;
            end
            else if (busy_reg)
            begin
                unique case (step_reg)
                    STEP_LO:
                    begin
                        step_reg <= STEP_HI;
                    end
                    STEP_HI:
                    begin
                        step_reg <= STEP_SUM;
                    end
                    STEP_SUM:
                    begin
                        step_reg <= STEP_REM;
                    end
                    STEP_REM:
                    begin
                        busy_reg <= 1'b0;
                        step_reg <= STEP_LO;
                    end
                    default:
                    begin
                        busy_reg <= 1'b0;
                        step_reg <= STEP_LO;
                    end
                endcase
            end
        end
    end

    // dividend, partial products, quotient low bits and remainder
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dividend_reg <= req.operand;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                STEP_LO:
                begin
                    lo_reg <= mul_p;
                end
                STEP_HI:
                begin
                    hi_reg <= mul_p;
                end
                STEP_SUM:
                begin
                    quot_reg <= quot_low;
                end
                STEP_REM:
                begin
                    rem_reg <= rem_low;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int BUCKETS      = 1024;
    localparam int WAYS         = 4;
    localparam int SLOT_COUNT   = BUCKETS * WAYS;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_SLACK  = 100;
    localparam int REPORT_LIMIT = 10;
    localparam int HOT_KEYS     = 16;
    localparam int HOT_BUCKETS  = 3;

    localparam logic [bhs_pkg::KEY_W-1:0] KEY_TOP = 31'h7FFF_FFFF;

    // receiver stall patterns
    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_BURSTY
    } rx_mode_t;

    // one expected response beat
    typedef struct packed {
        logic                        found;
        bhs_pkg::status_t            status;
        logic [bhs_pkg::COUNT_W-1:0] count;
    } set_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        req_valid;
    logic                        req_ready;
    logic [1:0]                  operation;
    logic [bhs_pkg::KEY_W-1:0]   key;
    logic [bhs_pkg::KEY_W-1:0]   new_key;
    logic                        rsp_valid;
    logic                        rsp_ready;
    logic                        found;
    logic [1:0]                  status;
    logic [bhs_pkg::COUNT_W-1:0] entry_count;

    // shadow copy of the table
    logic [bhs_pkg::KEY_W-1:0] shadow_key [SLOT_COUNT];
    bit                        shadow_valid [SLOT_COUNT];
    int unsigned               shadow_total;

    set_result_t      pending_results [$];
    int unsigned      mismatch_count;
    int unsigned      result_index;
    int               hold_request;

    // keys concentrated on a few buckets so that hits and full buckets are common
    logic [bhs_pkg::KEY_W-1:0] hot_keys [HOT_KEYS];
    logic [9:0]                hot_bucket [HOT_BUCKETS];

    bucketed_hash_set #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .operation   (operation),
        .key         (key),
        .new_key     (new_key),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .found       (found),
        .status      (status),
        .entry_count (entry_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // slot holding k, or -1 when absent
    function automatic int locate_key(input logic [bhs_pkg::KEY_W-1:0] k);
        int base;
        base = int'(k % BUCKETS) * WAYS;
        for (int w = 0; w < WAYS; w++)
        begin
            if (shadow_valid[base + w] && shadow_key[base + w] == k)
                return base + w;
        end
        return -1;
    endfunction

    // insert into the lowest free way, full bucket drops the key
    function automatic bhs_pkg::status_t store_key(input logic [bhs_pkg::KEY_W-1:0] k);
        int base;
        if (locate_key(k) >= 0)
            return bhs_pkg::ST_OK;
        base = int'(k % BUCKETS) * WAYS;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!shadow_valid[base + w])
            begin
                shadow_valid[base + w] = 1'b1;
                shadow_key[base + w]   = k;
                shadow_total++;
                return bhs_pkg::ST_OK;
            end
        end
        return bhs_pkg::ST_FULL;
    endfunction

    function automatic void drop_slot(input int slot);
        shadow_valid[slot] = 1'b0;
        if (shadow_total > 0)
            shadow_total--;
    endfunction

    // apply one operation to the shadow table and give its response
    function automatic set_result_t apply_set_op(input bhs_pkg::op_t op,
                                                 input logic [bhs_pkg::KEY_W-1:0] k,
                                                 input logic [bhs_pkg::KEY_W-1:0] nk);
        int          slot;
        set_result_t r;
        slot     = locate_key(k);
        r.found  = (slot >= 0);
        r.status = bhs_pkg::ST_OK;
        case (op)
            bhs_pkg::OP_INSERT:
                r.status = store_key(k);
            bhs_pkg::OP_DELETE:
            begin
                if (slot >= 0)
                    drop_slot(slot);
            end
            bhs_pkg::OP_REPLACE:
            begin
                if (slot >= 0)
                begin
                    drop_slot(slot);
                    r.status = store_key(nk);
                end
                else
                    r.status = bhs_pkg::ST_ABSENT;
            end
            default:
                ;
        endcase
        r.count = (shadow_total > bhs_pkg::COUNT_MAX) ?
                  bhs_pkg::COUNT_MAX : shadow_total[bhs_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // mostly hot keys, some fresh keys in hot buckets, some anywhere
    function automatic logic [bhs_pkg::KEY_W-1:0] draw_key();
        logic [31:0] r32;
        int          pick;
        r32  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return hot_keys[$urandom_range(0, HOT_KEYS - 1)];
        else if (pick < 85)
            return {r32[20:0], hot_bucket[$urandom_range(0, HOT_BUCKETS - 1)]};
        else
            return r32[bhs_pkg::KEY_W-1:0];
    endfunction

    // present one request beat and hold it until accepted
    task automatic send_item(input bhs_pkg::op_t op, input logic [bhs_pkg::KEY_W-1:0] k,
                             input logic [bhs_pkg::KEY_W-1:0] nk);
        req_valid <= 1'b1;
        operation <= op;
        key       <= k;
        new_key   <= nk;
        do
        begin
            @(posedge clk);
        end
        while (req_ready !== 1'b1);
        pending_results.push_back(apply_set_op(op, k, nk));
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // stop sending until every response is back
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("response %0d %s: expected %0d, got %0d", result_index, what, want, got);
    endtask

    // insert, delete and search at the key extremes
    task automatic test_basic_ops();
        send_item(bhs_pkg::OP_SEARCH, '0, '0);
        send_item(bhs_pkg::OP_INSERT, '0, KEY_TOP);
        send_item(bhs_pkg::OP_INSERT, '0, '0);
        send_item(bhs_pkg::OP_INSERT, KEY_TOP, '0);
        send_item(bhs_pkg::OP_SEARCH, KEY_TOP, KEY_TOP);
        send_item(bhs_pkg::OP_DELETE, 31'h0001_2345, '0);
        send_item(bhs_pkg::OP_DELETE, '0, '0);
        send_item(bhs_pkg::OP_SEARCH, '0, '0);
        send_item(bhs_pkg::OP_INSERT, '0, '0);
    endtask

    // fill the top bucket, overflow it, free a middle way and refill
    task automatic test_full_bucket();
        send_item(bhs_pkg::OP_INSERT, 31'h7FFF_FBFF, '0);
        send_item(bhs_pkg::OP_INSERT, 31'h7FFF_F7FF, '0);
        send_item(bhs_pkg::OP_INSERT, 31'h0000_03FF, '0);
        send_item(bhs_pkg::OP_INSERT, 31'h0000_07FF, '0);
        send_item(bhs_pkg::OP_DELETE, 31'h7FFF_FBFF, '0);
        send_item(bhs_pkg::OP_INSERT, 31'h0000_07FF, '0);
        send_item(bhs_pkg::OP_INSERT, 31'h7FFF_FBFF, '0);
    endtask

    // replace: absent key, same key, target present, target bucket full
    task automatic test_replace_cases();
        send_item(bhs_pkg::OP_REPLACE, 31'h2AAA_AAAA, KEY_TOP);
        send_item(bhs_pkg::OP_REPLACE, '0, '0);
        send_item(bhs_pkg::OP_REPLACE, '0, KEY_TOP);
        send_item(bhs_pkg::OP_INSERT, 31'h0000_0400, '0);
        send_item(bhs_pkg::OP_INSERT, 31'h0000_0800, '0);
        send_item(bhs_pkg::OP_INSERT, 31'h0000_0C00, '0);
        send_item(bhs_pkg::OP_INSERT, '0, '0);
        send_item(bhs_pkg::OP_REPLACE, 31'h0000_07FF, 31'h0000_1000);
        send_item(bhs_pkg::OP_REPLACE, 31'h0000_0400, 31'h5555_5555);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_request = 400;
        for (int i = 0; i < 8; i++)
            send_item(bhs_pkg::OP_INSERT, {21'(i), 10'h155}, '0);
        send_item(bhs_pkg::OP_SEARCH, {21'd3, 10'h155}, '0);
        send_item(bhs_pkg::OP_REPLACE, {21'd1, 10'h155}, {21'd9, 10'h155});
    endtask

    // bursts of random operations with random gaps
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned  sent;
        int unsigned  burst;
        int           pick;
        int           gap;
        logic [31:0]  r32;
        bhs_pkg::op_t op;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < n_items; i++)
            begin
                // new hot set now and then
                if (sent % 97 == 0)
                begin
                    for (int b = 0; b < HOT_BUCKETS; b++)
                    begin
                        r32 = $urandom;
                        pick = $urandom_range(0, 5);
                        hot_bucket[b] = (pick == 0) ? 10'h3FF : (pick == 1) ? 10'h000 : r32[9:0];
                    end
                    for (int h = 0; h < HOT_KEYS; h++)
                    begin
                        r32 = $urandom;
                        hot_keys[h] = {r32[20:0], hot_bucket[$urandom_range(0, HOT_BUCKETS - 1)]};
                    end
                end
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    op = bhs_pkg::OP_INSERT;
                else if (pick < 55)
                    op = bhs_pkg::OP_DELETE;
                else if (pick < 75)
                    op = bhs_pkg::OP_SEARCH;
                else
                    op = bhs_pkg::OP_REPLACE;
                send_item(op, draw_key(), draw_key());
                sent++;
            end
            pick = $urandom_range(0, 9);
            if (pick < 5)
                gap = 0;
            else if (pick < 8)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(5, 80);
            pause_sender(gap);
        end
    endtask

    // sender pauses until the block is empty, then resumes
    task automatic test_drain_pause();
        wait_for_results();
        send_item(bhs_pkg::OP_SEARCH, KEY_TOP, '0);
        send_item(bhs_pkg::OP_INSERT, 31'h0000_0001, KEY_TOP);
    endtask

    // stimulus
    initial
    begin
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        operation    <= bhs_pkg::OP_INSERT;
        key          <= '0;
        new_key      <= '0;
        shadow_total  = 0;
        hold_request  = 0;
        for (int s = 0; s < SLOT_COUNT; s++)
            shadow_valid[s] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_ops();
        test_full_bucket();
        test_replace_cases();
        test_backpressure();
        test_random_traffic(700);
        test_drain_pause();
        test_random_traffic(800);
        wait_for_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver ready pattern, long hold counted here
    initial
    begin
        int       hold_left;
        int       span_left;
        int       stall_left;
        rx_mode_t mode;
        logic     take;
        hold_left  = 0;
        span_left  = 0;
        stall_left = 0;
        mode       = RX_STEADY;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (span_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 2));
                span_left = $urandom_range(30, 300);
            end
            span_left--;
            if (hold_left > 0)
            begin
                take = 1'b0;
                hold_left--;
            end
            else
            begin
                case (mode)
                    RX_STEADY:
                        take = 1'b1;
                    RX_COIN:
                        take = 1'($urandom_range(0, 1));
                    default:
                    begin
                        if (stall_left == 0 && $urandom_range(0, 9) == 0)
                            stall_left = $urandom_range(1, 60);
                        if (stall_left > 0)
                        begin
                            take = 1'b0;
                            stall_left--;
                        end
                        else
                            take = 1'b1;
                    end
                endcase
            end
            rsp_ready <= take;
        end
    end

    // compare each response beat with the oldest expectation
    initial
    begin
        set_result_t want;
        mismatch_count = 0;
        result_index   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch("unexpected beat, entry_count", 0, 32'(entry_count));
                else
                begin
                    want = pending_results.pop_front();
                    if (found !== want.found)
                        flag_mismatch("found", 32'(want.found), 32'(found));
                    if (status !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(status));
                    if (entry_count !== want.count)
                        flag_mismatch("entry_count", 32'(want.count), 32'(entry_count));
                end
                result_index++;
            end
        end
    end

    // run limit
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bhs_pkg.sv
hw/rtl/bhs_mod_unit.sv
hw/rtl/bucketed_hash_set.sv
tb/sv/testbench.sv
